// ===== rtl/cmfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfr_pkg: shared types and constants of the CAN multi-frame reassembler
// Buffer sizing, result status codes, the frame and result payload structs,
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cmfr_pkg;

  localparam int unsigned BUFFER_BYTES = 32;
  localparam int unsigned MAX_RESULTS  = 32;

  localparam int unsigned FILL_W  = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned ADDR_W  = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned TOTAL_W = 6;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned CMP_W   = (FILL_W > MIN_W) ? FILL_W : MIN_W;
  localparam int unsigned PADDR_W = 3;

  // Result status codes.
  localparam logic [2:0] ST_PARTIAL      = 3'd0;
  localparam logic [2:0] ST_IGNORED      = 3'd1;
  localparam logic [2:0] ST_ID_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_TOGGLE_ERROR = 3'd3;
  localparam logic [2:0] ST_OVERFLOW     = 3'd4;
  localparam logic [2:0] ST_TOO_SHORT    = 3'd5;
  localparam logic [2:0] ST_COMPLETE     = 3'd6;

  // Register indexes on the configuration port.
  localparam logic REG_MIN_LENGTH = 1'b0;

  typedef struct packed {
    logic [3:0] frame_length;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] tail_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [TOTAL_W-1:0] total_length;
    logic               last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_frame;
    logic       open_xfer;
    logic       set_toggle;
    logic       abort_xfer;
    logic       write_byte;
    logic       commit_fill;
    logic       close_xfer;
    logic       emit_start;
    logic       emit_run;
    logic       resp_load;
    logic [2:0] resp_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sof;
    logic eof;
    logic active;
    logic id_match;
    logic toggle_ok;
    logic len_zero;
    logic overflow;
    logic write_done;
    logic too_short;
    logic fill_zero;
    logic out_free;
    logic emit_done;
  } stat_t;

endpackage

// ===== rtl/cmfr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfr_datapath: frame registers, transfer state, byte buffer and result
// Holds the accepted frame, the transfer tracking state, the assembly buffer
// memory and the output register. Acts on controller commands and configuration writes.
// ----------------------------------------------------------------------------
module cmfr_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmfr_pkg::in_t          in_data_i,
  input  cmfr_pkg::cmd_t         cmd_i,
  output cmfr_pkg::stat_t        stat_o,
  input  logic                   cfg_we_i,
  input  logic [cmfr_pkg::MIN_W-1:0] cfg_wdata_i,
  output logic [cmfr_pkg::MIN_W-1:0] min_length_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output cmfr_pkg::out_t         out_data_o
);
  import cmfr_pkg::*;

  // Accepted frame.
  logic [3:0] len_q;
  logic [7:0] bytes_q [7];
  logic [7:0] tail_q;

  // Transfer state.
  logic              active_q, active_d;
  logic [4:0]        cur_id_q, cur_id_d;
  logic              last_toggle_q, last_toggle_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [MIN_W-1:0]  min_length_q;

  // Buffer and unload counters.
  logic [7:0]        mem_q [BUFFER_BYTES];
  logic [2:0]        wcnt_q;
  logic [FILL_W-1:0] n_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  rcnt_q;
  logic [CNT_W-1:0]  lcnt_q;
  logic              pv_q;
  logic [7:0]        rd_data_q;

  logic              out_valid_q;
  out_t              out_q, out_d;

  logic              sof, eof, tog;
  logic [4:0]        id;
  logic [2:0]        payload;
  logic [FILL_W-1:0] base;
  logic [FILL_W:0]   sum;
  logic [ADDR_W-1:0] waddr;
  logic              out_free, can_load, rd_en, emit_done;
  logic [CNT_W-1:0]  count_d;
  logic [TOTAL_W-1:0] resp_total;

  assign sof     = tail_q[7];
  assign eof     = tail_q[6];
  assign tog     = tail_q[5];
  assign id      = tail_q[4:0];
  assign payload = 3'(len_q - 4'd1);
  assign base    = sof ? '0 : fill_q;
  assign sum     = (FILL_W + 1)'(base) + (FILL_W + 1)'(payload);
  assign waddr   = ADDR_W'(fill_q + FILL_W'(wcnt_q));

  assign out_free  = !out_valid_q || !out_stall_i;
  assign can_load  = cmd_i.emit_run && pv_q && out_free;
  assign rd_en     = cmd_i.emit_run && (rcnt_q != count_q) && (!pv_q || can_load);
  assign emit_done = can_load && ((lcnt_q + CNT_W'(1)) == count_q);

  always_comb begin
    stat_o.sof        = sof;
    stat_o.eof        = eof;
    stat_o.active     = active_q;
    stat_o.id_match   = (id == cur_id_q);
    stat_o.toggle_ok  = (tog != last_toggle_q);
    stat_o.len_zero   = (len_q == 4'd0);
    stat_o.overflow   = (sum > (FILL_W + 1)'(BUFFER_BYTES));
    stat_o.write_done = (wcnt_q == payload);
    stat_o.too_short  = (CMP_W'(fill_q) < CMP_W'(min_length_q));
    stat_o.fill_zero  = (fill_q == '0);
    stat_o.out_free   = out_free;
    stat_o.emit_done  = emit_done;
  end

  always_comb begin
    active_d      = active_q;
    cur_id_d      = cur_id_q;
    last_toggle_d = last_toggle_q;
    fill_d        = fill_q;
    if (cmd_i.open_xfer) begin
      active_d      = 1'b1;
      cur_id_d      = id;
      last_toggle_d = 1'b0;
      fill_d        = '0;
    end
    if (cmd_i.set_toggle) begin
      last_toggle_d = tog;
    end
    if (cmd_i.commit_fill) begin
      fill_d = fill_q + FILL_W'(payload);
    end
    if (cmd_i.abort_xfer || cmd_i.close_xfer) begin
      active_d = 1'b0;
      fill_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      cur_id_q      <= '0;
      last_toggle_q <= 1'b0;
      fill_q        <= '0;
      min_length_q  <= MIN_W'(1);
    end else begin
      active_q      <= active_d;
      cur_id_q      <= cur_id_d;
      last_toggle_q <= last_toggle_d;
      fill_q        <= fill_d;
      if (cfg_we_i) begin
        min_length_q <= cfg_wdata_i;
      end
    end
  end

  assign min_length_o = min_length_q;

  // Frame capture; a length code above eight counts as eight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      len_q      <= (in_data_i.frame_length > 4'd8) ? 4'd8 : in_data_i.frame_length;
      bytes_q[0] <= in_data_i.byte0;
      bytes_q[1] <= in_data_i.byte1;
      bytes_q[2] <= in_data_i.byte2;
      bytes_q[3] <= in_data_i.byte3;
      bytes_q[4] <= in_data_i.byte4;
      bytes_q[5] <= in_data_i.byte5;
      bytes_q[6] <= in_data_i.byte6;
      tail_q     <= in_data_i.tail_byte;
    end
  end

  always_comb begin
    if (32'(fill_q) > 32'(MAX_RESULTS)) begin
      count_d = CNT_W'(MAX_RESULTS);
    end else begin
      count_d = CNT_W'(fill_q);
    end
  end

  // One payload byte is written per cycle; the unload keeps one read ahead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q  <= '0;
      n_q     <= '0;
      count_q <= '0;
      rcnt_q  <= '0;
      lcnt_q  <= '0;
      pv_q    <= 1'b0;
    end else begin
      if (cmd_i.load_frame) begin
        wcnt_q <= '0;
      end else if (cmd_i.write_byte) begin
        wcnt_q <= wcnt_q + 3'd1;
      end
      if (cmd_i.close_xfer) begin
        n_q     <= fill_q;
        count_q <= count_d;
      end
      if (cmd_i.emit_start) begin
        rcnt_q <= '0;
        lcnt_q <= '0;
        pv_q   <= 1'b0;
      end else begin
        if (rd_en) begin
          rcnt_q <= rcnt_q + CNT_W'(1);
          pv_q   <= 1'b1;
        end else if (can_load) begin
          pv_q <= 1'b0;
        end
        if (can_load) begin
          lcnt_q <= lcnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_byte) begin
      mem_q[waddr] <= bytes_q[wcnt_q];
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rcnt_q[ADDR_W-1:0]];
    end
  end

  always_comb begin
    case (cmd_i.resp_code) inside
      ST_PARTIAL, ST_IGNORED:    resp_total = TOTAL_W'(fill_q);
      ST_TOO_SHORT, ST_COMPLETE: resp_total = TOTAL_W'(n_q);
      default:                   resp_total = '0;
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.resp_load) begin
      out_d.status       = cmd_i.resp_code;
      out_d.data_byte    = 8'd0;
      out_d.byte_index   = '0;
      out_d.total_length = resp_total;
      out_d.last         = 1'b1;
    end else if (can_load) begin
      out_d.status       = ST_COMPLETE;
      out_d.data_byte    = rd_data_q;
      out_d.byte_index   = INDEX_W'(lcnt_q);
      out_d.total_length = TOTAL_W'(n_q);
      out_d.last         = emit_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_load || can_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/cmfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfr_ctrl: frame handling state machine
// Decides how each frame is treated, sequences the buffer writes, closes the
// transfer and drives the single-result or byte-by-byte unload.
// ----------------------------------------------------------------------------
module cmfr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cmfr_pkg::stat_t stat_i,
  output cmfr_pkg::cmd_t  cmd_o
);
  import cmfr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_CLOSE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] code_q, code_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.resp_code = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_frame = 1'b1;
          state_d          = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat_i.sof && !stat_i.active) begin
          code_d  = ST_IGNORED;
          state_d = S_RESP;
        end else if (!stat_i.sof && !stat_i.id_match) begin
          cmd_o.abort_xfer = 1'b1;
          code_d           = ST_ID_MISMATCH;
          state_d          = S_RESP;
        end else if (!stat_i.sof && !stat_i.eof && !stat_i.toggle_ok) begin
          cmd_o.abort_xfer = 1'b1;
          code_d           = ST_TOGGLE_ERROR;
          state_d          = S_RESP;
        end else begin
          cmd_o.open_xfer  = stat_i.sof;
          cmd_o.set_toggle = !stat_i.sof && !stat_i.eof;
          // A frame without a tail byte is treated as an overflow too.
          if (stat_i.len_zero || stat_i.overflow) begin
            cmd_o.abort_xfer = 1'b1;
            code_d           = ST_OVERFLOW;
            state_d          = S_RESP;
          end else begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (!stat_i.write_done) begin
          cmd_o.write_byte = 1'b1;
        end else begin
          cmd_o.commit_fill = 1'b1;
          if (stat_i.eof) begin
            state_d = S_CLOSE;
          end else begin
            code_d  = ST_PARTIAL;
            state_d = S_RESP;
          end
        end
      end
      S_CLOSE: begin
        cmd_o.close_xfer = 1'b1;
        if (stat_i.too_short) begin
          code_d  = ST_TOO_SHORT;
          state_d = S_RESP;
        end else if (stat_i.fill_zero) begin
          code_d  = ST_COMPLETE;
          state_d = S_RESP;
        end else begin
          cmd_o.emit_start = 1'b1;
          state_d          = S_EMIT;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd_o.emit_run = 1'b1;
        if (stat_i.emit_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_PARTIAL;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

// ===== rtl/can_multiframe_reassembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_multiframe_reassembler: multi-frame CAN transfer reassembly
// Frames enter on the in channel (valid/stall) and results leave on the out
// channel (valid/stall). min_length is written over the APB-style port.
//
// One frame is handled at a time. A frame is decided in S_EVAL, its payload
// bytes are written into the buffer one per cycle in S_WRITE (at most 7), and
// the fill is then committed. A frame that gives a single result loads it
// from S_RESP once the output is free, and the controller returns to S_IDLE
// to take the next frame. Frames rejected before the write phase go from
// S_EVAL straight to S_RESP. An end frame also passes through S_CLOSE.
// A completed transfer of n bytes then unloads one byte per cycle from the
// buffer memory while the output is not stalled, one read ahead of the
// output register. The buffer has a single write port, which sets the
// one-byte-per-cycle pace. Reset clears the transfer state and sets
// min_length to 1; buffer contents are not cleared. A stalled output holds
// its result and the block waits.
// ----------------------------------------------------------------------------
module can_multiframe_reassembler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cmfr_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cmfr_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import cmfr_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic              cfg_we;
  logic [MIN_W-1:0]  min_length;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MIN_LENGTH);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_LENGTH) begin
      prdata = 32'(min_length);
    end
  end

  cmfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cmfr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata[MIN_W-1:0]),
    .min_length_o (min_length),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the CAN multi-frame reassembler
// Frames are driven from a queue with random gaps, and results are taken with
// random stalls. Each accepted frame runs through a local copy of the transfer
// state, which predicts the status and byte stream that the block must return.
// min_length is written and read back over the APB-style port between phases.
// ----------------------------------------------------------------------------
module testbench;
  import cmfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 50;

  typedef enum {FLAW_NONE, FLAW_ID, FLAW_TOGGLE, FLAW_EMPTY_DLC, FLAW_DROP_START} flaw_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               apb_sel = 1'b0;
  logic               apb_enable = 1'b0;
  logic               apb_write = 1'b0;
  logic [PADDR_W-1:0] apb_addr = '0;
  logic [31:0]        apb_wdata = '0;
  logic [31:0]        apb_rdata;
  logic               apb_ready;

  // Transfer state as the block should hold it.
  logic [5:0]         min_len = 6'd1;
  logic               xfer_active = 1'b0;
  logic [4:0]         xfer_id = '0;
  logic               xfer_toggle = 1'b0;
  int                 xfer_fill = 0;
  logic [7:0]         xfer_bytes [BUFFER_BYTES];

  in_t                frame_q [$];
  out_t               reassembly_out_q [$];
  out_t               awaited;
  int                 frames_queued = 0;
  int                 errors = 0;
  int                 cycles = 0;
  int                 tx_wait = 0;
  int                 rx_wait = 0;
  int                 rx_hold_left = 0;
  logic               rx_hold = 1'b0;
  logic               no_idle = 1'b0;
  logic               in_taken = 1'b0;
  logic               out_taken = 1'b0;

  can_multiframe_reassembler u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (apb_sel),
    .penable     (apb_enable),
    .pwrite      (apb_write),
    .paddr       (apb_addr),
    .pwdata      (apb_wdata),
    .prdata      (apb_rdata),
    .pready      (apb_ready)
  );

  always #5 clk = ~clk;

  function automatic void report_fault(string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, what);
  endfunction

  function automatic int pick_wait();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic void await_result(logic [2:0] st, logic [7:0] d, int idx, int total,
                                       logic fin);
    out_t r;
    r.status       = st;
    r.data_byte    = d;
    r.byte_index   = INDEX_W'(idx);
    r.total_length = TOTAL_W'(total);
    r.last         = fin;
    reassembly_out_q.push_back(r);
  endfunction

  function automatic void abort_transfer(logic [2:0] st);
    xfer_fill   = 0;
    xfer_active = 1'b0;
    await_result(st, 8'd0, 0, 0, 1'b1);
  endfunction

  // Works out every result that one accepted frame causes.
  function automatic void reassemble_frame(in_t f);
    logic [7:0] pb [7];
    logic       sof, eof, tog;
    logic [4:0] id;
    int         len, payload, n, count;
    pb  = '{f.byte0, f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6};
    sof = f.tail_byte[7];
    eof = f.tail_byte[6];
    tog = f.tail_byte[5];
    id  = f.tail_byte[4:0];
    len = (f.frame_length > 8) ? 8 : int'(f.frame_length);

    if (sof) begin
      xfer_fill   = 0;
      xfer_id     = id;
      xfer_active = 1'b1;
      xfer_toggle = 1'b0;
    end else if (!xfer_active) begin
      await_result(ST_IGNORED, 8'd0, 0, xfer_fill, 1'b1);
      return;
    end else if (id != xfer_id) begin
      abort_transfer(ST_ID_MISMATCH);
      return;
    end

    // Only intermediate frames must alternate the toggle.
    if (!sof && !eof) begin
      if (tog == xfer_toggle) begin
        abort_transfer(ST_TOGGLE_ERROR);
        return;
      end
      xfer_toggle = tog;
    end

    if (len == 0) begin
      abort_transfer(ST_OVERFLOW);
      return;
    end
    payload = len - 1;
    if (xfer_fill + payload > BUFFER_BYTES) begin
      abort_transfer(ST_OVERFLOW);
      return;
    end
    for (int i = 0; i < payload; i++) xfer_bytes[xfer_fill + i] = pb[i];
    xfer_fill += payload;

    if (!eof) begin
      await_result(ST_PARTIAL, 8'd0, 0, xfer_fill, 1'b1);
      return;
    end

    xfer_active = 1'b0;
    n = xfer_fill;
    xfer_fill = 0;
    if (n < int'(min_len)) begin
      await_result(ST_TOO_SHORT, 8'd0, 0, n, 1'b1);
    end else if (n == 0) begin
      await_result(ST_COMPLETE, 8'd0, 0, 0, 1'b1);
    end else begin
      count = (n > MAX_RESULTS) ? MAX_RESULTS : n;
      for (int i = 0; i < count; i++) begin
        await_result(ST_COMPLETE, xfer_bytes[i], i, n, i + 1 == count);
      end
    end
  endfunction

  function automatic in_t frame_of(logic [3:0] len, logic [7:0] tail);
    in_t f;
    f.frame_length = len;
    {f.byte0, f.byte1, f.byte2, f.byte3} = $urandom;
    {f.byte4, f.byte5, f.byte6} = 24'($urandom);
    f.tail_byte = tail;
    return f;
  endfunction

  function automatic void offer(in_t f);
    frame_q.push_back(f);
    frames_queued++;
  endfunction

  // Splits a transfer of nbytes into frames, optionally breaking one of them.
  function automatic void queue_transfer(int nbytes, flaw_e flaw);
    in_t        f;
    int         rem, chunk, k;
    logic [4:0] id;
    logic       tog;
    bit         broken;
    id     = 5'($urandom);
    rem    = nbytes;
    k      = 0;
    broken = 1'b0;
    do begin
      chunk = (rem < 7) ? rem : 7;
      if (chunk > 0 && $urandom_range(0, 3) == 0) chunk = $urandom_range(0, chunk);
      rem -= chunk;
      tog = (k == 0 || rem == 0) ? 1'($urandom) : k[0];
      f = frame_of(4'(chunk + 1), {k == 0, rem == 0, tog, id});
      // A length code above eight still carries seven payload bytes.
      if (chunk == 7 && $urandom_range(0, 3) == 0) f.frame_length = 4'($urandom_range(9, 15));
      if (!broken && flaw != FLAW_NONE && (rem == 0 || $urandom_range(0, 2) == 0)) begin
        broken = 1'b1;
        case (flaw)
          FLAW_ID: begin
            f.tail_byte[4:0] = id ^ 5'($urandom_range(1, 31));
          end
          FLAW_TOGGLE: begin
            f.tail_byte[5] = ~f.tail_byte[5];
          end
          FLAW_EMPTY_DLC: begin
            f.frame_length = '0;
          end
          default: begin
          end
        endcase
      end
      if (!(flaw == FLAW_DROP_START && k == 0)) offer(f);
      k++;
    end while (rem > 0);
  endfunction

  function automatic void queue_random(int goal);
    int r, nbytes;
    while (frames_queued < goal) begin
      r = $urandom_range(0, 99);
      nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 32) : $urandom_range(0, 32);
      if (r < 10) begin
        offer(frame_of(4'($urandom), 8'($urandom)));
      end else if (r < 20) begin
        queue_transfer($urandom_range(33, 45), FLAW_NONE);
      end else if (r < 40) begin
        queue_transfer(nbytes, flaw_e'($urandom_range(FLAW_ID, FLAW_DROP_START)));
      end else begin
        queue_transfer(nbytes, FLAW_NONE);
      end
    end
  endfunction

  // Writes min_length, reads it back, and ends on a rising edge.
  task automatic set_min_length(logic [5:0] value);
    @(negedge clk);
    apb_sel    <= 1'b1;
    apb_enable <= 1'b0;
    apb_write  <= 1'b1;
    apb_addr   <= PADDR_W'(REG_MIN_LENGTH) << 2;
    apb_wdata  <= 32'(value);
    @(negedge clk);
    apb_enable <= 1'b1;
    do @(posedge clk); while (!apb_ready);
    min_len = value;
    @(negedge clk);
    apb_enable <= 1'b0;
    apb_write  <= 1'b0;
    @(negedge clk);
    apb_enable <= 1'b1;
    do @(posedge clk); while (!apb_ready);
    if (apb_rdata[5:0] !== value) begin
      report_fault($sformatf("min_length read back %0d, wrote %0d", apb_rdata[5:0], value));
    end
    @(negedge clk);
    apb_sel    <= 1'b0;
    apb_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (frame_q.size() > 0 || in_valid || reassembly_out_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Frame driver.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait--;
      end else if (frame_q.size() > 0) begin
        in_data  <= frame_q.pop_front();
        in_valid <= 1'b1;
        tx_wait = pick_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the driver keeps offering frames.
  always @(negedge clk) begin
    rx_hold <= rx_hold_left > 0;
    if (rx_hold_left > 0) rx_hold_left--;
  end

  always @(negedge clk) begin
    if (out_taken) rx_wait = pick_wait();
    out_stall <= rx_hold || rx_wait > 0;
    if (rx_wait > 0) rx_wait--;
  end

  // Prediction on accepted frames and checking of accepted results.
  always @(posedge clk) begin
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) reassemble_frame(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (reassembly_out_q.size() == 0) begin
        report_fault($sformatf("unexpected result: status %0d data %02h index %0d total %0d",
                               out_data.status, out_data.data_byte, out_data.byte_index,
                               out_data.total_length));
      end else begin
        awaited = reassembly_out_q.pop_front();
        if (out_data !== awaited) begin
          report_fault($sformatf({"result mismatch (expected/actual): status %0d/%0d ",
                                  "data %02h/%02h index %0d/%0d total %0d/%0d last %0b/%0b"},
                                 awaited.status, out_data.status,
                                 awaited.data_byte, out_data.data_byte,
                                 awaited.byte_index, out_data.byte_index,
                                 awaited.total_length, out_data.total_length,
                                 awaited.last, out_data.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_t f;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with min_length at its reset value.
    offer(frame_of(4'd8, {3'b001, 5'd7}));    // continuation while idle
    offer(frame_of(4'd1, {3'b110, 5'd0}));    // empty single frame, too short
    f = frame_of(4'd8, {3'b110, 5'd31});
    {f.byte0, f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6} = '0;
    offer(f);
    f = frame_of(4'd8, {3'b111, 5'd31});
    {f.byte0, f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6} = '1;
    offer(f);
    offer(frame_of(4'd0, {3'b110, 5'd1}));    // no tail byte present
    offer(frame_of(4'd15, {3'b110, 5'd2}));   // length code above eight
    // A full 32-byte transfer.
    offer(frame_of(4'd8, {3'b100, 5'd9}));
    for (int k = 1; k <= 3; k++) offer(frame_of(4'd8, {2'b00, k[0], 5'd9}));
    offer(frame_of(4'd5, {3'b010, 5'd9}));
    offer(frame_of(4'd4, {3'b100, 5'd3}));
    offer(frame_of(4'd4, {3'b001, 5'd4}));    // wrong transfer id
    offer(frame_of(4'd3, {3'b100, 5'd10}));
    offer(frame_of(4'd3, {3'b000, 5'd10}));   // toggle did not alternate
    // Runs past the buffer; the closing frame then finds no open transfer.
    offer(frame_of(4'd8, {3'b100, 5'd17}));
    for (int k = 1; k <= 4; k++) offer(frame_of(4'd8, {2'b00, k[0], 5'd17}));
    offer(frame_of(4'd2, {3'b010, 5'd17}));
    settle();

    set_min_length(6'd0);
    rx_hold_left = 400;
    queue_random(120);
    settle();

    set_min_length(6'd32);
    queue_random(200);
    settle();

    set_min_length(6'd63);
    queue_random(250);
    settle();

    set_min_length(6'($urandom_range(2, 31)));
    no_idle = 1'b1;
    queue_random(330);
    settle();
    no_idle = 1'b0;

    set_min_length(6'd1);
    queue_random(440);
    settle();

    errors += reassembly_out_q.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
